FILE: rtl/core/ebw_pkg.sv
// Shared types, stage enables and Q15 rounding multiply for the body-to-world rotation.
package ebw_pkg;

    localparam int Q15_BITS = 16;
    localparam int ROM_BITS = 15;
    localparam int DCM_BITS = 18;
    localparam int FRAC     = 15;

    typedef logic signed [Q15_BITS-1:0] t_q15;
    typedef logic signed [DCM_BITS-1:0] t_dcm;

    typedef struct packed {
        logic s0;
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

    // Q15 x Q15 product, rounded half up
    function automatic t_q15 f_mq(input t_q15 a, input t_q15 b);
        logic signed [2*Q15_BITS-1:0] p;
        p = (2*Q15_BITS)'(a) * (2*Q15_BITS)'(b);
        p = p + (2*Q15_BITS)'(1 << (FRAC - 1));
        p = p >>> FRAC;
        return p[Q15_BITS-1:0];
    endfunction

endpackage

FILE: rtl/core/ebw_trig.sv
// Sine and cosine lookup of one binary angle from a quarter-wave ROM.
module ebw_trig #(
    parameter int ANGLE_BITS = 16,
    parameter int ADDR_BITS  = 10
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output ebw_pkg::t_q15         o_sin,
    output ebw_pkg::t_q15         o_cos
);

    localparam int PB     = ANGLE_BITS - 2;
    localparam int N      = 1 << ADDR_BITS;
    localparam int EXT    = PB + ADDR_BITS;
    localparam int SH_R   = (PB > ADDR_BITS) ? PB - ADDR_BITS : 0;
    localparam int SH_L   = (PB < ADDR_BITS) ? ADDR_BITS - PB : 0;
    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {PB{1'b0}}};

    typedef logic [ebw_pkg::ROM_BITS-1:0] t_rom [0:N];

    // restoring long division, evaluated at elaboration only
    function automatic longint unsigned f_udiv(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_rom f_build();
        t_rom rom;
        int k;
        int n;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned d;
        longint unsigned e;
        longint sum;
        for (k = 0; k <= N; k++) begin
            x = (longint'(k) * 64'd1686629713 + (64'd1 << (ADDR_BITS - 1))) >> ADDR_BITS;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (n = 0; n < 8; n++) begin
                d = longint'((2 * n + 2) * (2 * n + 3));
                term = f_udiv((term * x2) >> 30, d);
                if (n[0]) begin
                    sum = sum + longint'(term);
                end else begin
                    sum = sum - longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            e = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (e > 64'd32767) begin
                e = 64'd32767;
            end
            rom[k] = e[ebw_pkg::ROM_BITS-1:0];
        end
        return rom;
    endfunction

    localparam t_rom ROM = f_build();

    // {negate, address}
    function automatic logic [ADDR_BITS+1:0] f_map(input logic [ANGLE_BITS-1:0] a);
        logic [1:0]           q;
        logic [EXT-1:0]       pos;
        logic [ADDR_BITS-1:0] idx;
        logic [ADDR_BITS:0]   ad;
        q   = a[ANGLE_BITS-1 -: 2];
        pos = EXT'(a[PB-1:0]);
        pos = (pos << SH_L) >> SH_R;
        idx = pos[ADDR_BITS-1:0];
        ad  = q[0] ? ((ADDR_BITS+1)'(N) - {1'b0, idx}) : {1'b0, idx};
        return {q[1], ad};
    endfunction

    logic [ADDR_BITS+1:0] n_map_s;
    logic [ADDR_BITS+1:0] n_map_c;
    logic [ebw_pkg::ROM_BITS-1:0] r_rom_s;
    logic [ebw_pkg::ROM_BITS-1:0] r_rom_c;
    logic r_neg_s;
    logic r_neg_c;

    always_comb begin
        n_map_s = f_map(i_angle);
        n_map_c = f_map(i_angle + QUARTER);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rom_s <= ROM[n_map_s[ADDR_BITS:0]];
            r_rom_c <= ROM[n_map_c[ADDR_BITS:0]];
            r_neg_s <= n_map_s[ADDR_BITS+1];
            r_neg_c <= n_map_c[ADDR_BITS+1];
        end
    end

    assign o_sin = r_neg_s ? -ebw_pkg::t_q15'({1'b0, r_rom_s}) : ebw_pkg::t_q15'({1'b0, r_rom_s});
    assign o_cos = r_neg_c ? -ebw_pkg::t_q15'({1'b0, r_rom_c}) : ebw_pkg::t_q15'({1'b0, r_rom_c});

endmodule

FILE: rtl/core/ebw_dcm.sv
// Direction cosine matrix build: first-level products, then matrix entries.
module ebw_dcm #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  ebw_pkg::t_stage_en            i_en,
    input  ebw_pkg::t_q15                 i_sth,
    input  ebw_pkg::t_q15                 i_cth,
    input  ebw_pkg::t_q15                 i_sph,
    input  ebw_pkg::t_q15                 i_cph,
    input  ebw_pkg::t_q15                 i_sps,
    input  ebw_pkg::t_q15                 i_cps,
    input  logic signed [SAMPLE_BITS-1:0] i_v [3],
    output ebw_pkg::t_dcm                 o_d [3][3],
    output logic signed [SAMPLE_BITS-1:0] o_v [3]
);

    ebw_pkg::t_q15 r_cps_cth, r_sph_sth, r_cph_sps, r_sph_sps, r_cps_sth;
    ebw_pkg::t_q15 r_cph_cps, r_sps_sth, r_cps_sph, r_cth_sph, r_cph_cth, r_cth_sps;
    ebw_pkg::t_q15 r_sth, r_sph, r_cph, r_cps;
    logic signed [SAMPLE_BITS-1:0] r_v1 [3];
    logic signed [SAMPLE_BITS-1:0] r_v2 [3];
    ebw_pkg::t_dcm r_d [3][3];

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_cps_cth <= ebw_pkg::f_mq(i_cps, i_cth);
            r_sph_sth <= ebw_pkg::f_mq(i_sph, i_sth);
            r_cph_sps <= ebw_pkg::f_mq(i_cph, i_sps);
            r_sph_sps <= ebw_pkg::f_mq(i_sph, i_sps);
            r_cps_sth <= ebw_pkg::f_mq(i_cps, i_sth);
            r_cph_cps <= ebw_pkg::f_mq(i_cph, i_cps);
            r_sps_sth <= ebw_pkg::f_mq(i_sps, i_sth);
            r_cps_sph <= ebw_pkg::f_mq(i_cps, i_sph);
            r_cth_sph <= ebw_pkg::f_mq(i_cth, i_sph);
            r_cph_cth <= ebw_pkg::f_mq(i_cph, i_cth);
            r_cth_sps <= ebw_pkg::f_mq(i_cth, i_sps);
            r_sth     <= i_sth;
            r_sph     <= i_sph;
            r_cph     <= i_cph;
            r_cps     <= i_cps;
            r_v1      <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_d[0][0] <= ebw_pkg::DCM_BITS'(r_cps_cth);
            r_d[0][1] <= ebw_pkg::DCM_BITS'(ebw_pkg::f_mq(r_cps, r_sph_sth))
                       - ebw_pkg::DCM_BITS'(r_cph_sps);
            r_d[0][2] <= ebw_pkg::DCM_BITS'(r_sph_sps)
                       + ebw_pkg::DCM_BITS'(ebw_pkg::f_mq(r_cph, r_cps_sth));
            r_d[1][0] <= ebw_pkg::DCM_BITS'(r_cth_sps);
            r_d[1][1] <= ebw_pkg::DCM_BITS'(r_cph_cps)
                       + ebw_pkg::DCM_BITS'(ebw_pkg::f_mq(r_sph, r_sps_sth));
            r_d[1][2] <= ebw_pkg::DCM_BITS'(ebw_pkg::f_mq(r_cph, r_sps_sth))
                       - ebw_pkg::DCM_BITS'(r_cps_sph);
            r_d[2][0] <= -ebw_pkg::DCM_BITS'(r_sth);
            r_d[2][1] <= ebw_pkg::DCM_BITS'(r_cth_sph);
            r_d[2][2] <= ebw_pkg::DCM_BITS'(r_cph_cth);
            r_v2      <= r_v1;
        end
    end

    assign o_d = r_d;
    assign o_v = r_v2;

endmodule

FILE: rtl/core/ebw_mac.sv
// Matrix-vector products, row sums, rounding and saturation.
module ebw_mac #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  ebw_pkg::t_stage_en            i_en,
    input  ebw_pkg::t_dcm                 i_d [3][3],
    input  logic signed [SAMPLE_BITS-1:0] i_v [3],
    output logic signed [SAMPLE_BITS:0]   o_w [3]
);

    localparam int PW = SAMPLE_BITS + ebw_pkg::DCM_BITS;
    localparam int W  = PW + 2;
    localparam longint HI_L = (64'sd1 <<< SAMPLE_BITS) - 64'sd1;
    localparam longint LO_L = -(64'sd1 <<< SAMPLE_BITS);
    localparam logic signed [W-1:0] HI   = W'(HI_L);
    localparam logic signed [W-1:0] LO   = W'(LO_L);
    localparam logic signed [W-1:0] HALF = W'(1 << (ebw_pkg::FRAC - 1));

    logic signed [PW-1:0] r_p [3][3];
    logic signed [W-1:0] n_acc [3];
    logic signed [W-1:0] n_rnd [3];
    logic signed [SAMPLE_BITS:0] n_sat [3];
    logic signed [SAMPLE_BITS:0] r_w [3];

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= PW'(i_d[i][j]) * PW'(i_v[j]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_acc[i] = W'(r_p[i][0]) + W'(r_p[i][1]) + W'(r_p[i][2]);
            n_rnd[i] = (n_acc[i] + HALF) >>> ebw_pkg::FRAC;
            if (n_rnd[i] > HI) begin
                n_sat[i] = HI[SAMPLE_BITS:0];
            end else if (n_rnd[i] < LO) begin
                n_sat[i] = LO[SAMPLE_BITS:0];
            end else begin
                n_sat[i] = n_rnd[i][SAMPLE_BITS:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_w <= n_sat;
        end
    end

    assign o_w = r_w;

endmodule

FILE: rtl/core/euler_body_to_world_rotate_top.sv
// Top level of the Euler-angle body-to-world vector rotation pipeline.
//
// Input channel: i_valid / o_stall carry three binary angles (pitch, roll,
// yaw; full range is -pi..pi) and a body-frame vector. Output channel:
// o_valid / i_stall carry the rotated world vector, each component
// rounded and saturated to SAMPLE_BITS+1 bits.
// A request moves when valid is high and stall is low at a clock edge.
// One request per cycle while the pipeline is not stalled. Stages: ROM
// lookup, first-level trig products, matrix entries, matrix-vector
// products, row sum with rounding and saturation.
// Each stage holds only while it is full and the stage after it is held,
// so empty stages keep filling while the receiver stalls; o_stall rises
// only once all five stages are full and i_stall is high.
// Reset (i_rst_n low, synchronous) clears all valid bits; no results are
// pending afterwards. The sine ROM is constant content, no init pass.
module euler_body_to_world_rotate_top #(
    parameter int ANGLE_BITS           = 16,
    parameter int SAMPLE_BITS          = 16,
    parameter int SINE_TABLE_ADDR_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [ANGLE_BITS-1:0]  i_pitch_angle,
    input  logic signed [ANGLE_BITS-1:0]  i_roll_angle,
    input  logic signed [ANGLE_BITS-1:0]  i_yaw_angle,
    input  logic signed [SAMPLE_BITS-1:0] i_body_pitch_axis,
    input  logic signed [SAMPLE_BITS-1:0] i_body_roll_axis,
    input  logic signed [SAMPLE_BITS-1:0] i_body_yaw_axis,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS:0]   o_world_x,
    output logic signed [SAMPLE_BITS:0]   o_world_y,
    output logic signed [SAMPLE_BITS:0]   o_world_z
);

    logic [4:0] r_vld;
    ebw_pkg::t_stage_en n_en;

    ebw_pkg::t_q15 sth, cth, sph, cph, sps, cps;
    logic signed [SAMPLE_BITS-1:0] r_v0 [3];
    logic signed [SAMPLE_BITS-1:0] dcm_v [3];
    ebw_pkg::t_dcm dcm_d [3][3];
    logic signed [SAMPLE_BITS:0] mac_w [3];

    always_comb begin
        n_en.s4 = !r_vld[4] || !i_stall;
        n_en.s3 = !r_vld[3] || n_en.s4;
        n_en.s2 = !r_vld[2] || n_en.s3;
        n_en.s1 = !r_vld[1] || n_en.s2;
        n_en.s0 = !r_vld[0] || n_en.s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en.s0) r_vld[0] <= i_valid;
            if (n_en.s1) r_vld[1] <= r_vld[0];
            if (n_en.s2) r_vld[2] <= r_vld[1];
            if (n_en.s3) r_vld[3] <= r_vld[2];
            if (n_en.s4) r_vld[4] <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en.s0) begin
            r_v0[0] <= i_body_pitch_axis;
            r_v0[1] <= i_body_roll_axis;
            r_v0[2] <= i_body_yaw_axis;
        end
    end

    ebw_trig #(.ANGLE_BITS(ANGLE_BITS), .ADDR_BITS(SINE_TABLE_ADDR_BITS)) u_trig_th (
        .i_clk(i_clk), .i_en(n_en.s0), .i_angle(i_pitch_angle), .o_sin(sth), .o_cos(cth)
    );
    ebw_trig #(.ANGLE_BITS(ANGLE_BITS), .ADDR_BITS(SINE_TABLE_ADDR_BITS)) u_trig_ph (
        .i_clk(i_clk), .i_en(n_en.s0), .i_angle(i_roll_angle), .o_sin(sph), .o_cos(cph)
    );
    ebw_trig #(.ANGLE_BITS(ANGLE_BITS), .ADDR_BITS(SINE_TABLE_ADDR_BITS)) u_trig_ps (
        .i_clk(i_clk), .i_en(n_en.s0), .i_angle(i_yaw_angle), .o_sin(sps), .o_cos(cps)
    );

    ebw_dcm #(.SAMPLE_BITS(SAMPLE_BITS)) u_dcm (
        .i_clk(i_clk), .i_en(n_en),
        .i_sth(sth), .i_cth(cth), .i_sph(sph), .i_cph(cph), .i_sps(sps), .i_cps(cps),
        .i_v(r_v0), .o_d(dcm_d), .o_v(dcm_v)
    );

    ebw_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
        .i_clk(i_clk), .i_en(n_en), .i_d(dcm_d), .i_v(dcm_v), .o_w(mac_w)
    );

    assign o_stall   = !n_en.s0;
    assign o_valid   = r_vld[4];
    assign o_world_x = mac_w[1];
    assign o_world_y = mac_w[0];
    assign o_world_z = mac_w[2];

endmodule

FILE: rtl/core/ebw_checker.sv
// Port-level checks for the rotation pipeline, bound to the top level.
module ebw_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall
);

    a_reset_empty: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    a_stall_cause: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output free");

    a_out_hold: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (o_valid && i_stall) |=> o_valid)
        else $error("stalled output dropped");

    a_fill_when_drain: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) !i_stall |-> !o_stall)
        else $error("stall while receiver ready");

endmodule

bind euler_body_to_world_rotate_top ebw_checker u_ebw_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
    .o_stall(o_stall), .o_valid(o_valid), .i_stall(i_stall)
);
